@@ hdl/text_console_writer_top_defines.svh @@
// Assertion macros shared by the text console writer checker.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is low.
`define TCW_ASSERT_SAME(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while reset is low.
`define TCW_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tcw_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the text console writer.
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 4;

	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;
	localparam int COLOR_W = 8;

	localparam int S_TDATA_W = ((CHAR_W + IDX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((POS_W + CHAR_W + COLOR_W + 7) / 8) * 8;

	localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [COLOR_W-1:0] BLANK_RESET = 8'h07;

	// What the latched command asks for.
	typedef enum logic [2:0] {
		K_CHAR,
		K_NL,
		K_CR,
		K_TAB,
		K_READ,
		K_CLEAR,
		K_NOP
	} kind_t;

	// Cursor update applied at the end of a cycle.
	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_ADV,
		CUR_NL,
		CUR_CR,
		CUR_HOME
	} cur_op_t;

	typedef struct packed {
		logic    load;       // latch the input item
		logic    char_wr;    // write the character plane at the cursor
		logic    rd_en;      // read both planes at the requested cell
		cur_op_t cur_op;
		logic    sweep_all;  // start a blanking sweep over the whole store
		logic    sweep_row;  // start a blanking sweep over the top row and scroll
		logic    sweep_wr;   // blank the cell under the sweep pointer
		logic    blank_rst;  // blank with the reset attribute instead of the register
		logic    out_load;   // capture the result into the output register
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  last_col;
		logic  last_row;
		logic  tab_stop_next;
		logic  sweep_last;
	} dp_status_t;

endpackage

`default_nettype wire

@@ hdl/text_console_writer_top.sv @@
// Top level of the text console writer: stream ports, configuration port, controller and datapath.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: func; tdata: char_code, cell_index
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: cursor_pos, read_char, read_color
// cfg       in         cfg_wr_en (no wait)            cfg_wr_data: blank_color
//
// Each command is latched, executed, and then its result is handed over while the next command
// is taken; a tab writes its spaces one after another until the next stop or a wrap.
// A wrap or newline past the last row scrolls and blanks the scrolled-in row.
// Clear-screen sweeps every cell, one cell a cycle through the single store port.
// After reset the same sweep blanks the store, so s_axis_tready stays low until it ends.
// A stalled result holds only the last step of the next command.
`default_nettype none

module text_console_writer_top #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command stream.
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,  // char_code[7:0], cell_index[18:8]
	input  logic [tcw_pkg::FUNC_W-1:0]    s_axis_tuser,  // func[1:0]
	// Result stream.
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata,  // cursor_pos[10:0], read_char[18:11],
	                                                     // read_color[26:19]
	// Blank attribute register.
	input  logic                          cfg_wr_en,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wr_data
);
	import tcw_pkg::*;

	localparam int M_PAD = M_TDATA_W - POS_W - CHAR_W - COLOR_W;

	dp_cmd_t            cmd;
	dp_status_t         status;
	logic [POS_W-1:0]   cursor_pos;
	logic [CHAR_W-1:0]  read_char;
	logic [COLOR_W-1:0] read_color;

	// The controller owns both handshakes; the datapath never sees them directly.
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// The store is kept as a ring of rows, so a scroll moves a row offset and blanks one row
	// instead of copying the whole screen.
	tcw_datapath #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_func     (s_axis_tuser),
		.in_char     (s_axis_tdata[CHAR_W-1:0]),
		.in_idx      (s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W]),
		.cmd         (cmd),
		.status      (status),
		.cursor_pos  (cursor_pos),
		.read_char   (read_char),
		.read_color  (read_color)
	);

	assign m_axis_tdata = {{M_PAD{1'b0}}, read_color, read_char, cursor_pos};

endmodule

`default_nettype wire

@@ hdl/tcw_datapath.sv @@
// Datapath: character and attribute stores, cursor, scroll offset, sweep pointer, result register.
`default_nettype none

module tcw_datapath #(
	parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tcw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wr_data,
	input  logic [tcw_pkg::FUNC_W-1:0]   in_func,
	input  logic [tcw_pkg::CHAR_W-1:0]   in_char,
	input  logic [tcw_pkg::IDX_W-1:0]    in_idx,
	input  tcw_pkg::dp_cmd_t             cmd,
	output tcw_pkg::dp_status_t          status,
	output logic [tcw_pkg::POS_W-1:0]    cursor_pos,
	output logic [tcw_pkg::CHAR_W-1:0]   read_char,
	output logic [tcw_pkg::COLOR_W-1:0]  read_color
);
	import tcw_pkg::*;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SUM_W  = ADDR_W + 1;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam int CMP_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

	// Latched command.
	logic [FUNC_W-1:0]  func_q;
	logic [CHAR_W-1:0]  char_q;
	logic [IDX_W-1:0]   idx_q;

	logic [COLOR_W-1:0] blank_color_q;

	// Cursor: column, row, column modulo the tab stop, and linear position.
	logic [COL_W-1:0]   col_q, col_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [PH_W-1:0]    phase_q, phase_d;
	logic [ADDR_W-1:0]  pos_q, pos_d;

	// Physical offset of logical row 0; scrolling moves it by one row.
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  sweep_addr_q;
	logic [ADDR_W-1:0]  sweep_left_q;

	logic [CHAR_W-1:0]  char_mem  [CELLS];
	logic [COLOR_W-1:0] color_mem [CELLS];
	logic [CHAR_W-1:0]  rd_char_q;
	logic [COLOR_W-1:0] rd_color_q;

	logic [ADDR_W-1:0]  out_pos_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic [COLOR_W-1:0] out_color_q;

	kind_t              kind_c;
	logic               idx_ok_c;
	logic               last_col_c;
	logic               last_row_c;
	logic               tab_next_c;
	logic [SUM_W-1:0]   cur_sum_c;
	logic [SUM_W-1:0]   rd_sum_c;
	logic [ADDR_W-1:0]  cur_phys_c;
	logic [ADDR_W-1:0]  rd_phys_c;
	logic [ADDR_W-1:0]  mem_addr_c;
	logic [CHAR_W-1:0]  wr_char_c;
	logic [COLOR_W-1:0] blank_c;
	logic               char_we_c;
	logic               rd_go_c;
	logic               rd_hit_c;

	always_comb begin
		kind_c = K_NOP;
		unique case (func_q)
			FN_PUT: begin
				unique case (char_q)
					CH_NL:   kind_c = K_NL;
					CH_CR:   kind_c = K_CR;
					CH_TAB:  kind_c = K_TAB;
					default: kind_c = K_CHAR;
				endcase
			end
			FN_READ:  kind_c = K_READ;
			FN_CLEAR: kind_c = K_CLEAR;
			default:  kind_c = K_NOP;
		endcase
	end

	assign idx_ok_c   = CMP_W'(idx_q) < CMP_W'(CELLS);
	assign last_col_c = col_q == COL_W'(COLUMNS - 1);
	assign last_row_c = row_q == ROW_W'(ROWS - 1);
	assign tab_next_c = phase_q == PH_W'(TAB_STOP - 1);

	assign status = '{
		kind:          kind_c,
		last_col:      last_col_c,
		last_row:      last_row_c,
		tab_stop_next: tab_next_c,
		sweep_last:    sweep_left_q == '0
	};

	// Logical to physical address: add the row offset, fold once past the end.
	always_comb begin
		cur_sum_c  = SUM_W'(pos_q) + SUM_W'(base_q);
		rd_sum_c   = SUM_W'(idx_q) + SUM_W'(base_q);
		cur_phys_c = (cur_sum_c >= SUM_W'(CELLS)) ? ADDR_W'(cur_sum_c - SUM_W'(CELLS))
		                                          : ADDR_W'(cur_sum_c);
		rd_phys_c  = (rd_sum_c >= SUM_W'(CELLS)) ? ADDR_W'(rd_sum_c - SUM_W'(CELLS))
		                                         : ADDR_W'(rd_sum_c);
	end

	always_comb begin
		if (cmd.sweep_wr) begin
			mem_addr_c = sweep_addr_q;
		end else if (cmd.rd_en) begin
			mem_addr_c = rd_phys_c;
		end else begin
			mem_addr_c = cur_phys_c;
		end
	end

	assign blank_c   = cmd.blank_rst ? BLANK_RESET : blank_color_q;
	assign wr_char_c = cmd.sweep_wr ? CH_NUL : ((kind_c == K_TAB) ? CH_SPACE : char_q);
	assign char_we_c = cmd.sweep_wr | cmd.char_wr;
	assign rd_go_c   = cmd.rd_en & idx_ok_c;
	assign rd_hit_c  = (kind_c == K_READ) & idx_ok_c;

	always_ff @(posedge clk) begin
		if (char_we_c) begin
			char_mem[mem_addr_c] <= wr_char_c;
		end
		if (rd_go_c) begin
			rd_char_q <= char_mem[mem_addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			color_mem[mem_addr_c] <= blank_c;
		end
		if (rd_go_c) begin
			rd_color_q <= color_mem[mem_addr_c];
		end
	end

	always_comb begin
		col_d   = col_q;
		row_d   = row_q;
		phase_d = phase_q;
		pos_d   = pos_q;
		unique case (cmd.cur_op)
			CUR_ADV: begin
				if (last_col_c) begin
					col_d   = '0;
					phase_d = '0;
					if (last_row_c) begin
						pos_d = pos_q - ADDR_W'(COLUMNS - 1);
					end else begin
						row_d = row_q + ROW_W'(1);
						pos_d = pos_q + ADDR_W'(1);
					end
				end else begin
					col_d   = col_q + COL_W'(1);
					pos_d   = pos_q + ADDR_W'(1);
					phase_d = tab_next_c ? '0 : phase_q + PH_W'(1);
				end
			end
			CUR_NL: begin
				col_d   = '0;
				phase_d = '0;
				if (last_row_c) begin
					pos_d = pos_q - ADDR_W'(col_q);
				end else begin
					row_d = row_q + ROW_W'(1);
					pos_d = pos_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
				end
			end
			CUR_CR: begin
				col_d   = '0;
				phase_d = '0;
				pos_d   = pos_q - ADDR_W'(col_q);
			end
			CUR_HOME: begin
				col_d   = '0;
				row_d   = '0;
				phase_d = '0;
				pos_d   = '0;
			end
			default: begin
				col_d = col_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_color_q <= BLANK_RESET;
			col_q         <= '0;
			row_q         <= '0;
			phase_q       <= '0;
			pos_q         <= '0;
			base_q        <= '0;
			sweep_addr_q  <= '0;
			sweep_left_q  <= ADDR_W'(CELLS - 1);
		end else begin
			if (cfg_wr_en) begin
				blank_color_q <= cfg_wr_data;
			end
			col_q   <= col_d;
			row_q   <= row_d;
			phase_q <= phase_d;
			pos_q   <= pos_d;
			if (cmd.sweep_all) begin
				sweep_addr_q <= '0;
				sweep_left_q <= ADDR_W'(CELLS - 1);
				base_q       <= '0;
			end else if (cmd.sweep_row) begin
				// The old top row becomes the new bottom row.
				sweep_addr_q <= base_q;
				sweep_left_q <= ADDR_W'(COLUMNS - 1);
				base_q       <= (base_q == ADDR_W'(CELLS - COLUMNS)) ? '0
				                                                     : base_q + ADDR_W'(COLUMNS);
			end else if (cmd.sweep_wr) begin
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
				sweep_left_q <= sweep_left_q - ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			char_q <= in_char;
			idx_q  <= in_idx;
		end
		if (cmd.out_load) begin
			out_pos_q   <= pos_q;
			out_char_q  <= rd_hit_c ? rd_char_q : '0;
			out_color_q <= rd_hit_c ? rd_color_q : '0;
		end
	end

	assign cursor_pos = POS_W'(out_pos_q);
	assign read_char  = out_char_q;
	assign read_color = out_color_q;

endmodule

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
// Controller: command sequencing, blanking sweeps and the result handshake.
`default_nettype none

module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tcw_pkg::dp_status_t status,
	output tcw_pkg::dp_cmd_t    cmd
);
	import tcw_pkg::*;

	typedef enum logic [4:0] {
		ST_CLR    = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_EXEC   = 5'b00100,
		ST_SCROLL = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   boot_q;
	logic   out_valid_q;
	logic   out_free_c;

	assign out_free_c = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.cur_op = CUR_HOLD;
		unique case (state_q)
			ST_CLR: begin
				cmd.sweep_wr  = 1'b1;
				cmd.blank_rst = boot_q;
				if (status.sweep_last) begin
					state_d = boot_q ? ST_IDLE : ST_RESP;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (status.kind) inside
					K_CHAR, K_TAB: begin
						cmd.char_wr = 1'b1;
						cmd.cur_op  = CUR_ADV;
						if (status.last_col && status.last_row) begin
							cmd.sweep_row = 1'b1;
							state_d       = ST_SCROLL;
						end else if (status.kind == K_CHAR || status.last_col ||
						             status.tab_stop_next) begin
							state_d = ST_RESP;
						end
					end
					K_NL: begin
						cmd.cur_op = CUR_NL;
						if (status.last_row) begin
							cmd.sweep_row = 1'b1;
							state_d       = ST_SCROLL;
						end else begin
							state_d = ST_RESP;
						end
					end
					K_CR: begin
						cmd.cur_op = CUR_CR;
						state_d    = ST_RESP;
					end
					K_READ: begin
						cmd.rd_en = 1'b1;
						state_d   = ST_RESP;
					end
					K_CLEAR: begin
						cmd.cur_op    = CUR_HOME;
						cmd.sweep_all = 1'b1;
						state_d       = ST_CLR;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SCROLL: begin
				cmd.sweep_wr = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				// Hand the result over and take the next command in the same cycle.
				if (out_free_c) begin
					cmd.out_load = 1'b1;
					in_ready     = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR && status.sweep_last) begin
				boot_q <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/tcw_checker.sv @@
// Port-level checker for the text console writer, bound to the top level.
`default_nettype none

`include "text_console_writer_top_defines.svh"

module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CMP_W = ((POS_W > $clog2(CELLS + 1)) ? POS_W : $clog2(CELLS + 1)) + 1;

	logic s_xfer;
	logic m_stall;
	logic cursor_ok;

	assign s_xfer    = s_axis_tvalid && s_axis_tready;
	assign m_stall   = m_axis_tvalid && !m_axis_tready;
	assign cursor_ok = CMP_W'(m_axis_tdata[POS_W-1:0]) < CMP_W'(CELLS);

	// Commands are worked one at a time: the cycle after a transfer never takes another.
	`TCW_ASSERT_NEXT(a_one_cmd_at_a_time, clk, arst_n, s_xfer, !s_axis_tready, "back to back")
	// The reported cursor always lies inside the store.
	`TCW_ASSERT_SAME(a_cursor_in_range, clk, arst_n, m_axis_tvalid, cursor_ok, "cursor off store")
	`TCW_ASSERT_NEXT(a_result_held, clk, arst_n, m_stall, m_axis_tvalid, "result dropped")
	`TCW_ASSERT_NEXT(a_result_stable, clk, arst_n, m_stall, $stable(m_axis_tdata), "result changed")

endmodule

bind text_console_writer_top tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the text console writer: stream driver, result monitor and scoreboard.
`timescale 1ns / 100ps

module tb;
	import tcw_pkg::*;

	// Geometry of the console as built with default parameters.
	localparam int CELLS = COLUMNS_DEF * ROWS_DEF;

	// The unused command code has no name in the package.
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	// A clear-screen sweeps every cell once, and the reset sweep is as long.
	// This pause outlasts any single sweep; every sweep ends before its result is handed over.
	localparam int SETTLE_CYCLES = CELLS + 64;

	// The receiver's long hold-off, long enough for the block to back up into its input.
	localparam int HOLD_CYCLES = 300;

	// The limit covers the clears, the scrolls, random gaps on both sides and the settle pauses.
	localparam int LIMIT_CYCLES = 1_000_000;

	localparam int REPORT_LIMIT = 10;

	// One expected result transfer.
	typedef struct {
		logic [POS_W-1:0]   pos;
		logic [CHAR_W-1:0]  glyph;
		logic [COLOR_W-1:0] attr;
	} console_result_t;

	// Console predictor and result checker. It keeps its own copy of both planes,
	// the cursor and the blank attribute, and queues one result per command.
	class console_scoreboard;
		logic [CHAR_W-1:0]  glyphs [CELLS];
		logic [COLOR_W-1:0] attrs [CELLS];
		logic [COLOR_W-1:0] blank_attr;
		int unsigned        col;
		int unsigned        row;
		console_result_t    expected_q [$];
		int unsigned        failures;

		function new();
			blank_attr = BLANK_RESET;
			blank_span(0, CELLS);
			col = 0;
			row = 0;
			failures = 0;
		endfunction

		function void set_blank(logic [COLOR_W-1:0] attr);
			blank_attr = attr;
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		function int unsigned cursor_index();
			return row * COLUMNS_DEF + col;
		endfunction

		function void blank_span(int unsigned first, int unsigned count);
			for (int unsigned i = first; i < first + count; i++) begin
				glyphs[i] = CH_NUL;
				attrs[i] = blank_attr;
			end
		endfunction

		// Every row moves up by one and the bottom row comes in blank.
		function void scroll_up();
			for (int unsigned i = 0; i < CELLS - COLUMNS_DEF; i++) begin
				glyphs[i] = glyphs[i + COLUMNS_DEF];
				attrs[i] = attrs[i + COLUMNS_DEF];
			end
			blank_span(CELLS - COLUMNS_DEF, COLUMNS_DEF);
		endfunction

		// Wrap at the line end, then scroll once the cursor has left the last row.
		function void settle();
			if (col >= COLUMNS_DEF) begin
				col = 0;
				row++;
			end
			if (row >= ROWS_DEF) begin
				scroll_up();
				row = ROWS_DEF - 1;
			end
		endfunction

		// The character plane takes the byte; the cell keeps its attribute.
		function void store_glyph(logic [CHAR_W-1:0] ch);
			glyphs[row * COLUMNS_DEF + col] = ch;
			col++;
			settle();
		endfunction

		function void put_glyph(logic [CHAR_W-1:0] ch);
			int unsigned spaces;
			spaces = 0;
			if (ch == CH_NL) begin
				col = 0;
				row++;
				settle();
			end else if (ch == CH_CR) begin
				col = 0;
			end else if (ch == CH_TAB) begin
				// At least one space, then up to the next stop; a wrap ends the padding.
				do begin
					store_glyph(CH_SPACE);
					spaces++;
				end while ((col % TAB_STOP_DEF) != 0 && spaces < TAB_STOP_DEF);
			end else begin
				store_glyph(ch);
			end
		endfunction

		function void note_command(logic [FUNC_W-1:0] fn, logic [CHAR_W-1:0] ch,
				logic [IDX_W-1:0] idx);
			console_result_t r;
			r.glyph = '0;
			r.attr = '0;
			case (fn)
				FN_PUT: begin
					put_glyph(ch);
				end
				FN_READ: begin
					if (idx < CELLS) begin
						r.glyph = glyphs[idx];
						r.attr = attrs[idx];
					end
				end
				FN_CLEAR: begin
					blank_span(0, CELLS);
					col = 0;
					row = 0;
				end
				default: begin
				end
			endcase
			r.pos = POS_W'(cursor_index());
			expected_q.push_back(r);
		endfunction

		function void report(string field, int unsigned want, int unsigned got);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data);
			console_result_t want;
			logic [POS_W-1:0]   got_pos;
			logic [CHAR_W-1:0]  got_glyph;
			logic [COLOR_W-1:0] got_attr;
			got_pos = data[POS_W-1:0];
			got_glyph = data[POS_W +: CHAR_W];
			got_attr = data[POS_W + CHAR_W +: COLOR_W];
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: result transfer 0x%0h with nothing expected", $time, data);
				return;
			end
			want = expected_q.pop_front();
			if (got_pos !== want.pos)
				report("cursor_pos", want.pos, got_pos);
			if (got_glyph !== want.glyph)
				report("read_char", want.glyph, got_glyph);
			if (got_attr !== want.attr)
				report("read_color", want.attr, got_attr);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic [FUNC_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  cfg_wr_en;
	logic [COLOR_W-1:0]    cfg_wr_data;

	console_scoreboard sb = new();

	// Shared by the command driver, the stimulus, the result sink and the watchdog.
	bit          no_gaps = 1'b0;
	bit          hold_sink = 1'b0;
	int unsigned commands_sent = 0;
	int unsigned cycle_count = 0;

	text_console_writer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Hard stop in case the block hangs or a result never shows up.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[text_console_writer_top] ERROR");
			$finish;
		end
	end

	// Every result transfer is checked against the oldest prediction. Signals are read
	// right at the edge, so they still hold the values that the handshake saw.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// Result sink: random back-pressure, none while no_gaps is set, and one long
	// hold-off on request during which the command side keeps offering transfers.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				hold_sink = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= no_gaps || ($urandom_range(99) >= 22);
			end
		end
	end

	// Offers one command, with a random gap in front of it, and waits for its transfer.
	// The valid stays high into the next command when no gap is drawn.
	task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
			input logic [IDX_W-1:0] idx);
		while (!no_gaps && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {{(S_TDATA_W - CHAR_W - IDX_W){1'b0}}, idx, ch};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_command(fn, ch, idx);
		commands_sent++;
	endtask

	task automatic put(input logic [CHAR_W-1:0] ch);
		send_cmd(FN_PUT, ch, IDX_W'($urandom_range(2047)));
	endtask

	task automatic read_cell(input logic [IDX_W-1:0] idx);
		send_cmd(FN_READ, CHAR_W'($urandom_range(255)), idx);
	endtask

	task automatic clear_screen();
		send_cmd(FN_CLEAR, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
	endtask

	// Stops offering and waits until every predicted result has been transferred.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// The attribute register is only written once the block has gone quiet, so that
	// no sweep that is still running picks up the new value.
	task automatic write_blank(input logic [COLOR_W-1:0] attr);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= attr;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_blank(attr);
	endtask

	// A line of random bytes with the odd tab, sometimes long enough to wrap,
	// usually closed by a newline or a carriage return.
	task automatic text_run();
		int unsigned len;
		int unsigned tail;
		len = ($urandom_range(99) < 20) ? $urandom_range(60, 100) : $urandom_range(1, 20);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(99) < 6)
				put(CH_TAB);
			else
				put(CHAR_W'($urandom_range(255)));
		end
		tail = $urandom_range(99);
		if (tail < 50)
			put(CH_NL);
		else if (tail < 65)
			put(CH_CR);
	endtask

	// Reads mostly land just behind the cursor, where the latest writes are.
	task automatic random_read();
		int signed idx;
		if ($urandom_range(99) < 60) begin
			idx = int'(sb.cursor_index()) - int'($urandom_range(0, 2 * COLUMNS_DEF));
			if (idx < 0)
				idx = $urandom_range(0, CELLS - 1);
			read_cell(IDX_W'(idx));
		end else begin
			read_cell(IDX_W'($urandom_range(2047)));
		end
	endtask

	// Mostly well-formed text with newline bursts that push the cursor to the bottom
	// row and into scrolls, mixed with reads, unused codes and rare clears.
	task automatic random_phase(input int unsigned count);
		int unsigned target;
		int unsigned pick;
		target = commands_sent + count;
		while (commands_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				text_run();
			end else if (pick < 72) begin
				random_read();
			end else if (pick < 87) begin
				repeat ($urandom_range(1, 8)) put(CH_NL);
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 3)) put(CH_TAB);
			end else if (pick < 97) begin
				send_cmd(FN_UNUSED, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
			end else if (pick < 98) begin
				clear_screen();
			end else begin
				put(CH_CR);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset attribute. The first command waits out the
		// clearing sweep that follows reset.
		read_cell(IDX_W'(0));
		read_cell(IDX_W'(CELLS - 1));
		read_cell(IDX_W'(CELLS));                  // just past the store
		read_cell(IDX_W'(2047));                   // largest index the field holds
		send_cmd(FN_UNUSED, 8'hFF, 11'h7FF);
		put(8'h41);
		put(CH_NUL);
		put(8'hFF);
		put(CH_TAB);                               // one space up to the stop
		put(CH_TAB);                               // a full stop of spaces
		put(8'h7E);
		put(CH_CR);
		put(CH_NL);
		for (int unsigned i = 0; i < 5; i++)
			read_cell(IDX_W'(i));
		read_cell(IDX_W'(8));
		send_cmd(FN_CLEAR, 8'hFF, 11'h7FF);
		read_cell(IDX_W'(2));
		put(CH_TAB);
		read_cell(IDX_W'(3));

		// Back-to-back traffic on both sides, then the long receiver hold-off while
		// commands keep coming.
		no_gaps = 1'b1;
		random_phase(150);
		no_gaps = 1'b0;
		hold_sink = 1'b1;
		random_phase(150);

		// Attribute extremes; the scrolled-in and cleared cells show them.
		write_blank(8'h00);
		clear_screen();
		random_phase(240);
		write_blank(8'hFF);
		random_phase(120);
		drain();                                   // sender waits for every result
		random_phase(120);

		write_blank(COLOR_W'($urandom_range(255)));
		random_phase(240);
		write_blank(8'hA5);
		clear_screen();
		random_phase(400);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0) begin
			$display("[text_console_writer_top] OK");
		end else begin
			$display("[text_console_writer_top] ERROR");
		end
		$finish;
	end

endmodule
